>>> sv/ppbq_pkg.sv
package ppbq_pkg;

  // Default sizes of the two banks.
  localparam int BANK_DEPTH_DEF   = 4096;
  localparam int HANDLE_WIDTH_DEF = 32;

  // Width of the handle fields at the ports.
  localparam int FIELD_WIDTH = 32;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Memory commands and outcome of one accepted operation.
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic rd_a;
    logic rd_b;
    logic ok;
  } mem_cmd_t;

endpackage

>>> sv/ping_pong_buffer_queue.sv
// Double-buffered handle queue built on two banks of synchronous RAM.
// Input channel (in_valid/in_ready) carries op and push_handle: op selects a
// push of push_handle into the input bank or a pop from the top of the output
// bank. When the input bank is full on a push, or the output bank is empty on
// a pop, the two banks swap roles first; within one bank the order is LIFO.
// Output channel (out_valid/out_ready) carries one result per operation: ok,
// and pop_handle, which is zero on every push and on a refused pop.
// An input transfer reaches its result transfer through the registered RAM
// read in the read stage and then the output register.
// Throughput is one operation per cycle unless the receiver stalls; the bank
// counters decide each operation in the cycle it is accepted, and each bank
// has one write port and one read port, so no operation waits on the previous one.
// When the receiver stalls, one result sits in the output register and one
// more in the read stage; in_ready drops only when both are occupied.
// Reset clears the counters and bank roles and empties both stages; the RAM
// contents are not cleared, since only written entries are ever read back.
module ping_pong_buffer_queue #(
  parameter int BANK_DEPTH   = ppbq_pkg::BANK_DEPTH_DEF,
  parameter int HANDLE_WIDTH = ppbq_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [ppbq_pkg::FIELD_WIDTH-1:0] push_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            ok,
  output logic [ppbq_pkg::FIELD_WIDTH-1:0] pop_handle
);
  import ppbq_pkg::*;

  localparam int IDX_W = $clog2(BANK_DEPTH);

  logic                    accept;
  mem_cmd_t                cmd;
  logic [IDX_W-1:0]        wr_addr;
  logic [IDX_W-1:0]        rd_addr;
  logic [HANDLE_WIDTH-1:0] wr_data;
  logic [HANDLE_WIDTH-1:0] dout_a;
  logic [HANDLE_WIDTH-1:0] dout_b;

  // Read stage: the operation whose bank read is in flight.
  logic s1_valid;
  logic s1_ok;
  logic s1_pop;
  logic s1_from_a;
  logic s1_move;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign accept   = in_valid && in_ready;

  // Fit the port handle to the stored width.
  logic [HANDLE_WIDTH+FIELD_WIDTH-1:0] push_ext;
  assign push_ext = {{HANDLE_WIDTH{1'b0}}, push_handle};
  assign wr_data  = push_ext[HANDLE_WIDTH-1:0];

  ppbq_ctrl #(
    .BANK_DEPTH(BANK_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .op      (op),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr)
  );

  ppbq_ram #(
    .WIDTH(HANDLE_WIDTH),
    .DEPTH(BANK_DEPTH)
  ) u_bank_a (
    .clk     (clk),
    .wr_en   (cmd.wr_a),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_a),
    .rd_addr (rd_addr),
    .rd_data (dout_a)
  );

  ppbq_ram #(
    .WIDTH(HANDLE_WIDTH),
    .DEPTH(BANK_DEPTH)
  ) u_bank_b (
    .clk     (clk),
    .wr_en   (cmd.wr_b),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_b),
    .rd_addr (rd_addr),
    .rd_data (dout_b)
  );

  // Handle of the read stage; the RAM output holds while this stage waits.
  logic [HANDLE_WIDTH-1:0]             s1_handle;
  logic [HANDLE_WIDTH+FIELD_WIDTH-1:0] s1_handle_ext;
  always_comb begin
    s1_handle = '0;
    if (s1_pop && s1_ok) begin
      s1_handle = s1_from_a ? dout_a : dout_b;
    end
  end
  assign s1_handle_ext = {{FIELD_WIDTH{1'b0}}, s1_handle};

  // Read stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok     <= cmd.ok;
      s1_pop    <= (op == OP_POP);
      s1_from_a <= cmd.rd_a;
    end
  end

  // Output register; a result moves in when the slot is free or taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      ok         <= s1_ok;
      pop_handle <= s1_handle_ext[FIELD_WIDTH-1:0];
    end
  end

  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && s1_valid |-> !in_ready)
    else $error("input accepted with both result stages full");

  a_stage_advance : assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("result left the read stage but did not reach the output");

  a_push_no_handle : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_pop |-> s1_handle == '0)
    else $error("push result carries a nonzero handle");

endmodule

>>> sv/ppbq_ram.sv
module ppbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/ppbq_ctrl.sv
module ppbq_ctrl #(
  parameter int BANK_DEPTH = ppbq_pkg::BANK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          op,
  output ppbq_pkg::mem_cmd_t            cmd,
  output logic [$clog2(BANK_DEPTH)-1:0] wr_addr,
  output logic [$clog2(BANK_DEPTH)-1:0] rd_addr
);
  import ppbq_pkg::*;

  localparam int CNT_W = $clog2(BANK_DEPTH + 1);
  localparam int IDX_W = $clog2(BANK_DEPTH);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(BANK_DEPTH);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  logic             input_is_b;
  logic             input_is_b_next;
  logic [CNT_W-1:0] input_count;
  logic [CNT_W-1:0] input_count_next;
  logic [CNT_W-1:0] output_count;
  logic [CNT_W-1:0] output_count_next;

  // Decide swap, bank access and new counts for the operation in this cycle.
  always_comb begin
    cmd               = '0;
    wr_addr           = '0;
    rd_addr           = '0;
    input_is_b_next   = input_is_b;
    input_count_next  = input_count;
    output_count_next = output_count;
    if (accept) begin
      if (op == OP_PUSH) begin
        if (input_count == FULL) begin
          input_is_b_next   = !input_is_b;
          input_count_next  = output_count;
          output_count_next = input_count;
        end
        if (input_count_next != FULL) begin
          wr_addr          = input_count_next[IDX_W-1:0];
          cmd.wr_a         = !input_is_b_next;
          cmd.wr_b         = input_is_b_next;
          cmd.ok           = 1'b1;
          input_count_next = input_count_next + ONE;
        end
      end else begin
        if (output_count == '0) begin
          input_is_b_next   = !input_is_b;
          input_count_next  = output_count;
          output_count_next = input_count;
        end
        if (output_count_next != '0) begin
          output_count_next = output_count_next - ONE;
          rd_addr           = output_count_next[IDX_W-1:0];
          cmd.rd_a          = input_is_b_next;
          cmd.rd_b          = !input_is_b_next;
          cmd.ok            = 1'b1;
        end
      end
    end
  end

  // Bank roles and fill counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_is_b   <= 1'b0;
      input_count  <= '0;
      output_count <= '0;
    end else begin
      input_is_b   <= input_is_b_next;
      input_count  <= input_count_next;
      output_count <= output_count_next;
    end
  end

  // Total number of stored handles, for the checks below.
  logic [CNT_W:0] total;
  assign total = {1'b0, input_count} + {1'b0, output_count};

  a_in_count_range : assert property (@(posedge clk) disable iff (rst)
    input_count <= FULL)
    else $error("input bank count exceeds the bank depth");

  a_out_count_range : assert property (@(posedge clk) disable iff (rst)
    output_count <= FULL)
    else $error("output bank count exceeds the bank depth");

  a_one_access : assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.wr_a, cmd.wr_b, cmd.rd_a, cmd.rd_b}) <= 1)
    else $error("more than one bank access in one cycle");

  a_pop_total : assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_POP && cmd.ok |=> total == $past(total) - 1'b1)
    else $error("successful pop did not remove exactly one handle");

  a_push_total : assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_PUSH && cmd.ok |=> total == $past(total) + 1'b1)
    else $error("successful push did not add exactly one handle");

endmodule

>>> sim/ping_pong_buffer_queue_tb.sv
module ping_pong_buffer_queue_tb;
  import ppbq_pkg::*;

  localparam int DEPTH       = BANK_DEPTH_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic                   ok;
    logic [FIELD_WIDTH-1:0] handle;
  } outcome_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   op;
  logic [FIELD_WIDTH-1:0] push_handle;
  logic                   out_valid;
  logic                   out_ready;
  logic                   ok;
  logic [FIELD_WIDTH-1:0] pop_handle;

  // Shadow copy of the two banks, their roles and their fill counts.
  logic [FIELD_WIDTH-1:0] bank_mem [2][DEPTH];
  logic                   in_bank_sel;
  int unsigned            in_fill;
  int unsigned            out_fill;

  // Outcomes predicted for accepted operations, oldest first.
  outcome_t outcome_fifo[$];

  // Controls shared between the stimulus and the receiver.
  bit idle_on;
  bit hold_req;

  // Run statistics.
  int n_push_ok;
  int n_push_refused;
  int n_pop_ok;
  int n_pop_empty;
  int n_swaps;
  int n_checked;
  int n_errors;
  int n_input_stalls;
  int idle_run;

  ping_pong_buffer_queue dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .push_handle(push_handle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .pop_handle (pop_handle)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Swap the roles of the banks; each count travels with its bank.
  function automatic void swap_roles();
    int unsigned t;
    t           = in_fill;
    in_fill     = out_fill;
    out_fill    = t;
    in_bank_sel = !in_bank_sel;
    n_swaps++;
  endfunction

  // Apply one operation to the shadow state and return its outcome.
  function automatic outcome_t queue_op_outcome(input logic item_op,
                                                input logic [FIELD_WIDTH-1:0] item_handle);
    outcome_t res;
    res = '0;
    if (item_op == OP_PUSH) begin
      if (in_fill >= DEPTH) swap_roles();
      if (in_fill < DEPTH) begin
        bank_mem[in_bank_sel][in_fill] = item_handle;
        in_fill++;
        res.ok = 1'b1;
        n_push_ok++;
      end else begin
        n_push_refused++;
      end
    end else begin
      if (out_fill == 0) swap_roles();
      if (out_fill != 0) begin
        out_fill--;
        res.handle = bank_mem[!in_bank_sel][out_fill];
        res.ok     = 1'b1;
        n_pop_ok++;
      end else begin
        n_pop_empty++;
      end
    end
    return res;
  endfunction

  // Offer one operation, after an optional gap, and hold it until the transfer.
  task automatic send_item(input logic item_op, input logic [FIELD_WIDTH-1:0] item_handle);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    op          <= item_op;
    push_handle <= item_handle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome_fifo.push_back(queue_op_outcome(item_op, item_handle));
  endtask

  task automatic push_item(input logic [FIELD_WIDTH-1:0] item_handle);
    send_item(OP_PUSH, item_handle);
  endtask

  task automatic pop_item();
    send_item(OP_POP, $urandom);
  endtask

  // Stop offering and wait until every predicted outcome has been checked.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outcome_fifo.size() != 0) @(posedge clk);
  endtask

  // Pop until both banks are empty, then once more on the empty queue.
  task automatic drain_queue();
    while (in_fill + out_fill != 0) pop_item();
    pop_item();
  endtask

  // Pops right after reset find both banks empty.
  task automatic test_empty_after_reset();
    pop_item();
    pop_item();
  endtask

  // Extreme handle values come back in reverse order; a pop ignores its handle field.
  task automatic test_handle_extremes();
    push_item('0);
    push_item('1);
    push_item(32'hAAAA_AAAA);
    push_item(32'h5555_5555);
    push_item(32'h8000_0001);
    send_item(OP_POP, '1);
    repeat (4) pop_item();
    pop_item();
  endtask

  // A pop on an empty output bank swaps in the input bank first.
  task automatic test_swap_on_pop();
    push_item($urandom);
    push_item($urandom);
    pop_item();
    push_item($urandom);
    push_item($urandom);
    repeat (3) pop_item();
    pop_item();
  endtask

  // Build a deep stack in one bank, then empty everything back out.
  task automatic test_fill_and_drain();
    drain_queue();
    repeat (40) push_item($urandom);
    drain_queue();
  endtask

  // The receiver holds off while operations keep coming, so the input stalls.
  task automatic test_receiver_stall();
    hold_req = 1'b1;
    repeat (24) begin
      if ($urandom_range(0, 1) == 0) push_item($urandom);
      else pop_item();
    end
  endtask

  // The sender stops until all outcomes are in, then resumes.
  task automatic test_sender_pause();
    repeat (6) push_item($urandom);
    wait_for_results();
    repeat (6) pop_item();
  endtask

  // Random mix in phases of differing push weight, so the fill levels wander.
  task automatic test_random_mix(input int count, input int push_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < push_pct) push_item($urandom);
      else pop_item();
    end
  endtask

  // Receiver: random stall bursts, plus one long hold when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest predicted outcome.
  always @(posedge clk) begin
    outcome_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (outcome_fifo.size() == 0) begin
        $display("%0t: unexpected result ok=%0b pop_handle=%h", $time, ok, pop_handle);
        n_errors++;
      end else begin
        exp_res = outcome_fifo.pop_front();
        n_checked++;
        if (ok !== exp_res.ok) begin
          $display("%0t: ok mismatch, expected %0b, actual %0b", $time, exp_res.ok, ok);
          n_errors++;
        end
        if (pop_handle !== exp_res.handle) begin
          $display("%0t: pop_handle mismatch, expected %h, actual %h",
                   $time, exp_res.handle, pop_handle);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer; also count stalled input cycles.
  always @(posedge clk) begin
    if (in_valid && !in_ready) n_input_stalls++;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, outcome_fifo.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    op          = OP_PUSH;
    push_handle = '0;
    in_bank_sel = 1'b0;
    in_fill     = 0;
    out_fill    = 0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_after_reset();
    test_handle_extremes();
    test_swap_on_pop();
    test_receiver_stall();
    test_sender_pause();
    test_fill_and_drain();
    test_random_mix(120, 50);
    test_random_mix(120, 75);
    test_random_mix(120, 30);
    test_random_mix(120, 65);
    test_random_mix(120, 40);
    // Final stretch at full rate with no idling on either side.
    wait_for_results();
    idle_on = 1'b0;
    test_random_mix(120, 55);

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Pushes: %0d stored, %0d refused; pops: %0d returned, %0d empty; %0d bank swaps.",
             n_push_ok, n_push_refused, n_pop_ok, n_pop_empty, n_swaps);
    $display("Results checked: %0d, input stall cycles: %0d, mismatches: %0d.",
             n_checked, n_input_stalls, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
